FILE: rtl/tbg_pkg.sv
// ----------------------------------------------------------------------------
// Telegraph burst stepper package
// Shared widths, register indexes, reaction codes and controller types.
// ----------------------------------------------------------------------------
package tbg_pkg;

    // Defaults for the top-level parameters.
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TIME_FRAC_DEF   = 16;
    localparam int RATE_FRAC_DEF   = 16;

    // Fixed field widths.
    localparam int TIME_W    = 48;
    localparam int RATE_W    = 32;
    localparam int PROP_W    = 56;
    localparam int A0_W      = 58;
    localparam int LN_W      = 38;
    localparam int RAND_W    = 32;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_CNT_W = 32;

    // ln(2) as Q0.32.
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_OPEN       = 3'd0,
        REG_RATE_CLOSE      = 3'd1,
        REG_RATE_PRODUCE    = 3'd2,
        REG_RATE_DECAY      = 3'd3,
        REG_EQUIL_TIME      = 3'd4,
        REG_SAMPLE_INTERVAL = 3'd5,
        REG_TOTAL_TIME      = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        RX_OPEN    = 2'd0,
        RX_CLOSE   = 2'd1,
        RX_PRODUCE = 2'd2,
        RX_DECAY   = 2'd3
    } reaction_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_D0,
        ST_D1,
        ST_S0,
        ST_S1,
        ST_T0,
        ST_T1,
        ST_THR,
        ST_NORM,
        ST_LOG,
        ST_LN0,
        ST_LN1,
        ST_LN2,
        ST_LN3,
        ST_DIV,
        ST_UPD0,
        ST_UPD1
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_D0,
        OP_D1,
        OP_S0,
        OP_S1,
        OP_T0,
        OP_T1,
        OP_THR,
        OP_NORM,
        OP_LOG,
        OP_LN0,
        OP_LN1,
        OP_LN2,
        OP_LN3,
        OP_DIV,
        OP_UPD0,
        OP_UPD1
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] norm_step;
    } cmd_t;

    typedef struct packed {
        logic a0_zero;
    } status_t;

endpackage

FILE: rtl/tbg_ctrl.sv
// ----------------------------------------------------------------------------
// Telegraph burst stepper controller
// Sequences the datapath through one step per request and owns the handshakes.
// ----------------------------------------------------------------------------
module tbg_ctrl
    import tbg_pkg::*;
#(
    parameter int DIV_STEPS = 38
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output cmd_t    cmd,
    input  status_t status
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);
    localparam logic [CNT_W-1:0] NORM_LAST = CNT_W'(4);
    localparam logic [CNT_W-1:0] LOG_LAST  = CNT_W'(31);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_busy;

    assign out_busy  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign in_stall  = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and iteration counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_D0;
            ST_D0:   state_next = ST_D1;
            ST_D1:   state_next = ST_S0;
            ST_S0:   state_next = ST_S1;
            ST_S1:   state_next = ST_T0;
            ST_T0:   state_next = ST_T1;
            ST_T1:   state_next = ST_THR;
            ST_THR:
            begin
                cnt_next   = '0;
                state_next = status.a0_zero ? ST_UPD0 : ST_NORM;
            end
            ST_NORM:
            begin
                if (cnt_reg == NORM_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_LOG;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LOG:
            begin
                if (cnt_reg == LOG_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_LN0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LN0:  state_next = ST_LN1;
            ST_LN1:  state_next = ST_LN2;
            ST_LN2:  state_next = ST_LN3;
            ST_LN3:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_UPD0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UPD0: state_next = ST_UPD1;
            ST_UPD1: if (!out_busy) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd.op        = OP_NONE;
        cmd.norm_step = cnt_reg[2:0];
        case (state_reg)
            ST_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
            ST_D0:   cmd.op = OP_D0;
            ST_D1:   cmd.op = OP_D1;
            ST_S0:   cmd.op = OP_S0;
            ST_S1:   cmd.op = OP_S1;
            ST_T0:   cmd.op = OP_T0;
            ST_T1:   cmd.op = OP_T1;
            ST_THR:  cmd.op = OP_THR;
            ST_NORM: cmd.op = OP_NORM;
            ST_LOG:  cmd.op = OP_LOG;
            ST_LN0:  cmd.op = OP_LN0;
            ST_LN1:  cmd.op = OP_LN1;
            ST_LN2:  cmd.op = OP_LN2;
            ST_LN3:  cmd.op = OP_LN3;
            ST_DIV:  cmd.op = OP_DIV;
            ST_UPD0: cmd.op = OP_UPD0;
            ST_UPD1: cmd.op = out_busy ? OP_NONE : OP_UPD1;
            default: cmd.op = OP_NONE;
        endcase
    end

    // The output register fills when the final update runs and empties when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_UPD1 && !out_busy)
        begin
            out_valid_next = 1'b1;
        end
    end

endmodule

FILE: rtl/tbg_datapath.sv
// ----------------------------------------------------------------------------
// Telegraph burst stepper datapath
// Configuration, model state, shared multiplier, log unit, divider, results.
// ----------------------------------------------------------------------------
module tbg_datapath
    import tbg_pkg::*;
#(
    parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
    parameter int TIME_FRAC_BITS = TIME_FRAC_DEF,
    parameter int RATE_FRAC_BITS = RATE_FRAC_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic [RAND_W-1:0]     rand_time,
    input  logic [RAND_W-1:0]     rand_pick,
    output logic [1:0]            reaction,
    output logic [TIME_W-1:0]     step_time,
    output logic [TIME_W-1:0]     sim_time,
    output logic                  switch_is_open,
    output logic [OUT_CNT_W-1:0]  product_count,
    output logic [OUT_CNT_W-1:0]  burst_size,
    output logic [TIME_W-1:0]     interarrival,
    output logic                  interarrival_valid,
    output logic                  sample_due,
    output logic                  past_equil,
    output logic                  run_done,
    output logic                  stalled
);

    localparam int K    = RATE_FRAC_BITS + TIME_FRAC_BITS - 32;
    localparam int KPOS = (K > 0) ? K : 0;
    localparam int KNEG = (K < 0) ? -K : 0;
    localparam int DW   = LN_W + KPOS;

    localparam logic [PROP_W-1:0] PROP_MAX = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Configuration registers.
    logic [RATE_W-1:0] rate_open_reg, rate_close_reg, rate_produce_reg, rate_decay_reg;
    logic [TIME_W-1:0] equil_time_reg, sample_interval_reg, total_time_reg;

    // Model state.
    logic                   open_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [TIME_W-1:0]      time_now_reg, measured_reg, last_prod_reg;
    logic [31:0]            nsn_reg;
    logic                   prod_seen_reg;
    logic [31:0]            burst_cnt_reg;

    // Working registers for one step.
    logic [RAND_W-1:0] r1_reg, r2_reg;
    logic [63:0]       mul_reg, pd_lo_reg, ps_lo_reg;
    logic [PROP_W-1:0] an3_reg;
    logic [A0_W-1:0]   a0_reg, thr_reg;
    logic [31:0]       tl_reg;
    logic [TIME_W:0]   samp_lim_reg;
    logic [31:0]       u_reg, frac_reg;
    logic [4:0]        p_reg;
    logic [LN_W-1:0]   nl2_reg;
    logic [31:0]       lnlo_reg;
    logic [DW-1:0]     qd_reg;
    logic [A0_W-1:0]   rem_reg;
    logic [TIME_W-1:0] tau_reg;
    logic              past_reg, stall_reg;
    logic [1:0]        react_reg;

    // Output registers.
    logic [1:0]           o_reaction_reg;
    logic [TIME_W-1:0]    o_step_reg, o_sim_reg, o_inter_reg;
    logic                 o_open_reg, o_inter_v_reg, o_sample_reg, o_past_reg;
    logic                 o_done_reg, o_stalled_reg;
    logic [OUT_CNT_W-1:0] o_count_reg, o_burst_reg;

    // Shared multiplier operands.
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] cnt64;

    assign cnt64 = 64'(count_reg);
    assign prod  = mul_a * mul_b;

    always_comb
    begin
        mul_a = u_reg;
        mul_b = u_reg;
        case (cmd.op)
            OP_D0:
            begin
                mul_a = rate_decay_reg;
                mul_b = cnt64[31:0];
            end
            OP_D1:
            begin
                mul_a = rate_decay_reg;
                mul_b = cnt64[63:32];
            end
            OP_S0:
            begin
                mul_a = nsn_reg;
                mul_b = sample_interval_reg[31:0];
            end
            OP_S1:
            begin
                mul_a = nsn_reg;
                mul_b = 32'(sample_interval_reg[TIME_W-1:32]);
            end
            OP_T0:
            begin
                mul_a = r2_reg;
                mul_b = a0_reg[31:0];
            end
            OP_T1:
            begin
                mul_a = r2_reg;
                mul_b = 32'(a0_reg[A0_W-1:32]);
            end
            OP_LN1:
            begin
                mul_a = nl2_reg[31:0];
                mul_b = LN2_Q32;
            end
            OP_LN2:
            begin
                mul_a = 32'(nl2_reg[LN_W-1:32]);
                mul_b = LN2_Q32;
            end
            default:
            begin
                mul_a = u_reg;
                mul_b = u_reg;
            end
        endcase
    end

    // Propensities of the three switch reactions and their running sums.
    logic [A0_W-1:0] c0, c1, c2;
    assign c0 = open_reg ? '0 : A0_W'(rate_open_reg);
    assign c1 = c0 + (open_reg ? A0_W'(rate_close_reg) : '0);
    assign c2 = c1 + (open_reg ? A0_W'(rate_produce_reg) : '0);

    // Combinational helpers for the individual steps.
    logic [95:0]    an3_full, samp_full;
    logic [32:0]    sq;
    logic [4:0]     sh;
    logic [31:0]    norm_mask;
    logic [A0_W:0]  trial;
    logic [LN_W-1:0] lnv;
    logic [63:0]    qx;
    logic [TIME_W-1:0] tau;
    logic [TIME_W:0]   meas_sum, time_sum;
    logic              past;
    logic              sample;
    logic [1:0]        react;

    assign an3_full  = {32'b0, pd_lo_reg} + {mul_reg, 32'b0};
    assign samp_full = {32'b0, ps_lo_reg} + {mul_reg, 32'b0};
    assign sq        = prod[63:31];
    assign sh        = 5'd16 >> cmd.norm_step;
    assign norm_mask = ~(32'hFFFF_FFFF >> sh);
    assign trial     = {rem_reg, qd_reg[DW-1]};
    assign lnv       = mul_reg[LN_W-1:0] + LN_W'(lnlo_reg);
    assign qx        = 64'(qd_reg) >> KNEG;
    assign tau       = stall_reg ? TIME_MAX
                     : ((qx[63:TIME_W] != '0) ? TIME_MAX : qx[TIME_W-1:0]);
    assign past      = (time_now_reg > equil_time_reg);
    assign meas_sum  = {1'b0, measured_reg} + {1'b0, tau};
    assign time_sum  = {1'b0, time_now_reg} + {1'b0, tau};
    assign sample    = (time_now_reg > equil_time_reg)
                     && ({1'b0, measured_reg} > samp_lim_reg);

    always_comb
    begin
        if (c0 > thr_reg)
        begin
            react = RX_OPEN;
        end
        else if (c1 > thr_reg)
        begin
            react = RX_CLOSE;
        end
        else if (c2 > thr_reg)
        begin
            react = RX_PRODUCE;
        end
        else
        begin
            react = RX_DECAY;
        end
    end

    assign status.a0_zero = (a0_reg == '0);

    // Configuration and model state, both set to their reset values by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_open_reg       <= RATE_W'(65536);
            rate_close_reg      <= RATE_W'(65536);
            rate_produce_reg    <= RATE_W'(65536);
            rate_decay_reg      <= RATE_W'(65536);
            equil_time_reg      <= '0;
            sample_interval_reg <= TIME_W'(65536);
            total_time_reg      <= TIME_W'(6553600);
            open_reg            <= 1'b1;
            count_reg           <= '0;
            time_now_reg        <= '0;
            measured_reg        <= '0;
            last_prod_reg       <= '0;
            nsn_reg             <= 32'd1;
            prod_seen_reg       <= 1'b0;
            burst_cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RATE_OPEN:       rate_open_reg       <= cfg_data[RATE_W-1:0];
                    REG_RATE_CLOSE:      rate_close_reg      <= cfg_data[RATE_W-1:0];
                    REG_RATE_PRODUCE:    rate_produce_reg    <= cfg_data[RATE_W-1:0];
                    REG_RATE_DECAY:      rate_decay_reg      <= cfg_data[RATE_W-1:0];
                    REG_EQUIL_TIME:      equil_time_reg      <= cfg_data[TIME_W-1:0];
                    REG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_data[TIME_W-1:0];
                    REG_TOTAL_TIME:      total_time_reg      <= cfg_data[TIME_W-1:0];
                    default:             ;
                endcase
            end

            if (cmd.op == OP_UPD0)
            begin
                if (past)
                begin
                    measured_reg <= meas_sum[TIME_W] ? TIME_MAX : meas_sum[TIME_W-1:0];
                end
                time_now_reg <= time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
            end

            if (cmd.op == OP_UPD1)
            begin
                if (sample && nsn_reg != 32'hFFFF_FFFF)
                begin
                    nsn_reg <= nsn_reg + 32'd1;
                end
                if (!stall_reg)
                begin
                    case (react_reg)
                        RX_OPEN:
                        begin
                            open_reg <= 1'b1;
                        end
                        RX_CLOSE:
                        begin
                            open_reg      <= 1'b0;
                            burst_cnt_reg <= '0;
                        end
                        RX_PRODUCE:
                        begin
                            if (count_reg != '1)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            prod_seen_reg <= 1'b1;
                            last_prod_reg <= time_now_reg;
                            if (burst_cnt_reg != 32'hFFFF_FFFF)
                            begin
                                burst_cnt_reg <= burst_cnt_reg + 32'd1;
                            end
                        end
                        default:
                        begin
                            if (count_reg != '0)
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Working registers of the current step.
    always_ff @(posedge clk)
    begin
        mul_reg <= prod;
        case (cmd.op)
            OP_LOAD:
            begin
                r1_reg   <= (rand_time == '0) ? 32'd1 : rand_time;
                r2_reg   <= rand_pick;
                p_reg    <= 5'd31;
                frac_reg <= '0;
            end
            OP_D1:  pd_lo_reg <= mul_reg;
            OP_S0:  an3_reg <= (an3_full > 96'(PROP_MAX)) ? PROP_MAX : an3_full[PROP_W-1:0];
            OP_S1:
            begin
                ps_lo_reg <= mul_reg;
                a0_reg    <= c2 + A0_W'(an3_reg);
                u_reg     <= r1_reg;
            end
            OP_T0:
            begin
                samp_lim_reg <= (samp_full > 96'(TIME_MAX)) ? {1'b1, {TIME_W{1'b0}}}
                                                             : {1'b0, samp_full[TIME_W-1:0]};
            end
            OP_T1:  tl_reg <= mul_reg[63:32];
            OP_THR:
            begin
                thr_reg   <= mul_reg[A0_W-1:0] + A0_W'(tl_reg);
                stall_reg <= (a0_reg == '0);
            end
            OP_NORM:
            begin
                if ((u_reg & norm_mask) == '0)
                begin
                    u_reg <= u_reg << sh;
                    p_reg <= p_reg - sh;
                end
            end
            OP_LOG:
            begin
                // One squaring per cycle yields one fraction bit of log2.
                if (sq[32])
                begin
                    u_reg    <= sq[32:1];
                    frac_reg <= {frac_reg[30:0], 1'b1};
                end
                else
                begin
                    u_reg    <= sq[31:0];
                    frac_reg <= {frac_reg[30:0], 1'b0};
                end
            end
            OP_LN0: nl2_reg <= {(6'd32 - {1'b0, p_reg}), 32'b0} - {6'b0, frac_reg};
            OP_LN2: lnlo_reg <= mul_reg[63:32];
            OP_LN3:
            begin
                qd_reg  <= DW'(lnv) << KPOS;
                rem_reg <= '0;
            end
            OP_DIV:
            begin
                if (trial >= {1'b0, a0_reg})
                begin
                    rem_reg <= A0_W'(trial - {1'b0, a0_reg});
                    qd_reg  <= {qd_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[A0_W-1:0];
                    qd_reg  <= {qd_reg[DW-2:0], 1'b0};
                end
            end
            OP_UPD0:
            begin
                tau_reg   <= tau;
                past_reg  <= past;
                react_reg <= stall_reg ? RX_OPEN : react;
            end
            OP_UPD1:
            begin
                o_reaction_reg <= react_reg;
                o_step_reg     <= tau_reg;
                o_sim_reg      <= time_now_reg;
                o_past_reg     <= past_reg;
                o_sample_reg   <= sample;
                o_done_reg     <= (time_now_reg >= total_time_reg);
                o_stalled_reg  <= stall_reg;
                o_burst_reg    <= '0;
                o_inter_reg    <= '0;
                o_inter_v_reg  <= 1'b0;
                o_open_reg     <= open_reg;
                o_count_reg    <= OUT_CNT_W'(count_reg);
                if (!stall_reg)
                begin
                    case (react_reg)
                        RX_OPEN:
                        begin
                            o_open_reg <= 1'b1;
                        end
                        RX_CLOSE:
                        begin
                            o_open_reg  <= 1'b0;
                            o_burst_reg <= burst_cnt_reg;
                        end
                        RX_PRODUCE:
                        begin
                            if (count_reg != '1)
                            begin
                                o_count_reg <= OUT_CNT_W'(count_reg + 1'b1);
                            end
                            if (prod_seen_reg)
                            begin
                                o_inter_reg   <= time_now_reg - last_prod_reg;
                                o_inter_v_reg <= 1'b1;
                            end
                        end
                        default:
                        begin
                            if (count_reg != '0)
                            begin
                                o_count_reg <= OUT_CNT_W'(count_reg - 1'b1);
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign reaction           = o_reaction_reg;
    assign step_time          = o_step_reg;
    assign sim_time           = o_sim_reg;
    assign switch_is_open     = o_open_reg;
    assign product_count      = o_count_reg;
    assign burst_size         = o_burst_reg;
    assign interarrival       = o_inter_reg;
    assign interarrival_valid = o_inter_v_reg;
    assign sample_due         = o_sample_reg;
    assign past_equil         = o_past_reg;
    assign run_done           = o_done_reg;
    assign stalled            = o_stalled_reg;

endmodule

FILE: rtl/telegraph_burst_gillespie_step.sv
// ----------------------------------------------------------------------------
// Telegraph burst Gillespie stepper
// One direct-method step of a two-state switch with product creation/decay.
// ----------------------------------------------------------------------------
// Each request on the input channel carries two uniform random words and
// advances the simulated switch by one reaction. The result channel returns
// one result per request: the reaction, the drawn time step, the new time,
// the switch state, the product count and the burst, interarrival, sampling,
// run-end and no-reaction flags. The user must write registers through the plain
// configuration port only while the block is idle; the block does not enforce it.
// A step loads the request, forms the propensities, their sum, the sampling
// limit and the pick threshold, then normalises the time word, runs the
// 32-round log2 squaring loop on the shared multiplier, scales by ln(2) and
// runs the bit-serial restoring divider over DIV_STEPS quotient bits, with
// DIV_STEPS = 38 + max(RATE_FRAC_BITS + TIME_FRAC_BITS - 32, 0), before the
// final update; a zero total propensity skips normalising, log, scaling and division.
// The block takes a new request only once it has filled the output register.
// Reset puts the registers and the switch state at their documented values
// and leaves the output channel empty. The block holds the next request off
// while it works; a finished result waits in the output register while the
// receiver stalls, and the block accepts a new request meanwhile, holding
// only its final update until the register is free.
module telegraph_burst_gillespie_step
    import tbg_pkg::*;
#(
    parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
    parameter int TIME_FRAC_BITS = TIME_FRAC_DEF,
    parameter int RATE_FRAC_BITS = RATE_FRAC_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [RAND_W-1:0]    rand_time,
    input  logic [RAND_W-1:0]    rand_pick,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           reaction,
    output logic [TIME_W-1:0]    step_time,
    output logic [TIME_W-1:0]    sim_time,
    output logic                 switch_is_open,
    output logic [OUT_CNT_W-1:0] product_count,
    output logic [OUT_CNT_W-1:0] burst_size,
    output logic [TIME_W-1:0]    interarrival,
    output logic                 interarrival_valid,
    output logic                 sample_due,
    output logic                 past_equil,
    output logic                 run_done,
    output logic                 stalled
);

    // The divider produces one quotient bit per cycle of the scaled dividend.
    localparam int K         = RATE_FRAC_BITS + TIME_FRAC_BITS - 32;
    localparam int DIV_STEPS = LN_W + ((K > 0) ? K : 0);

    cmd_t    cmd;
    status_t status;

    tbg_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    tbg_datapath #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .TIME_FRAC_BITS (TIME_FRAC_BITS),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .rand_time          (rand_time),
        .rand_pick          (rand_pick),
        .reaction           (reaction),
        .step_time          (step_time),
        .sim_time           (sim_time),
        .switch_is_open     (switch_is_open),
        .product_count      (product_count),
        .burst_size         (burst_size),
        .interarrival       (interarrival),
        .interarrival_valid (interarrival_valid),
        .sample_due         (sample_due),
        .past_equil         (past_equil),
        .run_done           (run_done),
        .stalled            (stalled)
    );

endmodule

FILE: rtl/tbg_checker.sv
// ----------------------------------------------------------------------------
// Telegraph burst stepper checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tbg_checker
    import tbg_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        reaction,
    input logic [TIME_W-1:0] step_time,
    input logic [TIME_W-1:0] sim_time,
    input logic [OUT_CNT_W-1:0] burst_size,
    input logic              interarrival_valid,
    input logic              stalled
);

    // A result held by the receiver keeps its simulated time and time step.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sim_time) && $stable(step_time))
        else $error("stalled result changed");

    // With no reaction fired the step is infinite and the reaction code is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stalled |-> reaction == RX_OPEN && step_time == '1)
        else $error("zero-propensity result malformed");

    // Only a production reports an interarrival time.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && interarrival_valid |-> reaction == RX_PRODUCE && !stalled)
        else $error("interarrival on non-production");

    // Only a closing reports a burst, and time never lags the step just drawn.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (burst_size == '0 || reaction == RX_CLOSE) && sim_time >= step_time)
        else $error("burst or time inconsistent");

endmodule

bind telegraph_burst_gillespie_step tbg_checker u_chk (.*);

FILE: bench/tbg_step_checker.sv
// ----------------------------------------------------------------------------
// Telegraph burst stepper checker
// Watches both channels, predicts every result and compares all of its fields.
// ----------------------------------------------------------------------------
module tbg_step_checker
    import tbg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [RAND_W-1:0]    rand_time,
    input  logic [RAND_W-1:0]    rand_pick,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           reaction,
    input  logic [TIME_W-1:0]    step_time,
    input  logic [TIME_W-1:0]    sim_time,
    input  logic                 switch_is_open,
    input  logic [OUT_CNT_W-1:0] product_count,
    input  logic [OUT_CNT_W-1:0] burst_size,
    input  logic [TIME_W-1:0]    interarrival,
    input  logic                 interarrival_valid,
    input  logic                 sample_due,
    input  logic                 past_equil,
    input  logic                 run_done,
    input  logic                 stalled,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [1:0]  rx;
        logic [47:0] tau;
        logic [47:0] now;
        logic        open;
        logic [31:0] count;
        logic [31:0] burst;
        logic [47:0] inter;
        logic        inter_ok;
        logic        sample;
        logic        past;
        logic        done;
        logic        stall;
    } step_result_t;

    localparam logic [63:0] T_MAX = (64'd1 << 48) - 1;
    localparam logic [63:0] P_MAX = (64'd1 << 56) - 1;
    localparam logic [63:0] C_MAX = (64'd1 << 32) - 1;
    localparam int          SHIFT = 16 + 16 - 32;

    logic [63:0] k_open, k_close, k_make, k_decay, t_equil, t_sample, t_total;
    logic [63:0] sw_open, molecules, t_now, t_meas, sample_no, t_last_make, made_any;
    logic [63:0] burst_run;
    step_result_t awaited[$];

    function automatic logic [63:0] propensity(logic [63:0] k, logic [63:0] n);
        if (n != 0 && k > P_MAX / n)
            return P_MAX;
        return k * n;
    endfunction

    function automatic logic [63:0] add_time(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > T_MAX) ? T_MAX : s;
    endfunction

    // -ln(r/2^32) in Q.32 through a squaring log2.
    function automatic logic [63:0] minus_log(logic [63:0] r);
        int          p;
        logic [63:0] u, frac, l2;
        p = 31;
        frac = 0;
        if (r == 0)
            r = 1;
        while (p > 0 && r[p] == 1'b0)
            p--;
        u = r << (31 - p);
        for (int i = 0; i < 32; i++)
        begin
            u = (u * u) >> 31;
            frac = frac << 1;
            if (u >= (64'd1 << 32))
            begin
                frac[0] = 1'b1;
                u = u >> 1;
            end
        end
        l2 = (64'(32 - p) << 32) - frac;
        return (l2 >> 32) * 64'hB17217F8 + (((l2 & C_MAX) * 64'hB17217F8) >> 32);
    endfunction

    function automatic logic [63:0] draw_tau(logic [63:0] lnv, logic [63:0] a0);
        logic [63:0] q, rem;
        q = lnv / a0;
        rem = lnv % a0;
        for (int i = 0; i < SHIFT; i++)
        begin
            if (q > T_MAX)
                break;
            q = q << 1;
            rem = rem << 1;
            if (rem >= a0)
            begin
                rem = rem - a0;
                q[0] = 1'b1;
            end
        end
        return (q > T_MAX) ? T_MAX : q;
    endfunction

    function automatic step_result_t advance_switch(logic [63:0] r1, logic [63:0] r2);
        step_result_t res;
        logic [63:0]  an [4];
        logic [63:0]  a0, tau, thr, cum;
        logic         over;
        res = '0;
        an[0] = propensity(k_open, sw_open ? 64'd0 : 64'd1);
        an[1] = propensity(k_close, sw_open);
        an[2] = propensity(k_make, sw_open);
        an[3] = propensity(k_decay, molecules);
        a0 = an[0] + an[1] + an[2] + an[3];
        res.stall = (a0 == 0);
        res.rx = RX_OPEN;
        if (res.stall)
            tau = T_MAX;
        else
        begin
            tau = draw_tau(minus_log(r1), a0);
            thr = r2 * (a0 >> 32) + ((r2 * (a0 & C_MAX)) >> 32);
            cum = 0;
            res.rx = RX_DECAY;
            for (int n = 0; n < 4; n++)
            begin
                cum = cum + an[n];
                if (cum > thr)
                begin
                    res.rx = 2'(n);
                    break;
                end
            end
        end
        res.past = (t_now > t_equil);
        if (res.past)
            t_meas = add_time(t_meas, tau);
        t_now = add_time(t_now, tau);
        if (t_now > t_equil)
        begin
            over = (t_sample != 0 && sample_no > T_MAX / t_sample);
            if (!over && t_meas > sample_no * t_sample)
            begin
                res.sample = 1'b1;
                if (sample_no < C_MAX)
                    sample_no++;
            end
        end
        if (!res.stall)
        begin
            case (reaction_t'(res.rx))
                RX_OPEN: sw_open = 1;
                RX_CLOSE:
                begin
                    sw_open = 0;
                    res.burst = burst_run[31:0];
                    burst_run = 0;
                end
                RX_PRODUCE:
                begin
                    if (molecules < C_MAX)
                        molecules++;
                    if (made_any != 0)
                    begin
                        res.inter = 48'(t_now - t_last_make);
                        res.inter_ok = 1'b1;
                    end
                    made_any = 1;
                    t_last_make = t_now;
                    if (burst_run < C_MAX)
                        burst_run++;
                end
                default:
                    if (molecules > 0)
                        molecules--;
            endcase
        end
        res.tau = tau[47:0];
        res.now = t_now[47:0];
        res.open = sw_open[0];
        res.count = molecules[31:0];
        res.done = (t_now >= t_total);
        return res;
    endfunction

    step_result_t seen, want;

    always_comb
    begin
        seen = '{reaction, step_time, sim_time, switch_is_open, product_count, burst_size,
                 interarrival, interarrival_valid, sample_due, past_equil, run_done,
                 stalled};
    end

    assign pending = awaited.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_open = 65536; k_close = 65536; k_make = 65536; k_decay = 65536;
            t_equil = 0; t_sample = 65536; t_total = 6553600;
            sw_open = 1; molecules = 0; t_now = 0; t_meas = 0; sample_no = 1;
            t_last_make = 0; made_any = 0; burst_run = 0;
            awaited.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RATE_OPEN:       k_open = cfg_data[31:0];
                    REG_RATE_CLOSE:      k_close = cfg_data[31:0];
                    REG_RATE_PRODUCE:    k_make = cfg_data[31:0];
                    REG_RATE_DECAY:      k_decay = cfg_data[31:0];
                    REG_EQUIL_TIME:      t_equil = cfg_data;
                    REG_SAMPLE_INTERVAL: t_sample = cfg_data;
                    REG_TOTAL_TIME:      t_total = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h", seen);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h actual %h", want, seen);
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited.push_back(advance_switch(64'(rand_time), 64'(rand_pick)));
        end
    end

endmodule

FILE: bench/telegraph_burst_gillespie_step_test.sv
// ----------------------------------------------------------------------------
// Telegraph burst stepper testbench
// Drives random-word requests through several rate and time settings, with
// random gaps on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module telegraph_burst_gillespie_step_test;
    import tbg_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [RAND_W-1:0]    rand_time;
    logic [RAND_W-1:0]    rand_pick;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           reaction;
    logic [TIME_W-1:0]    step_time;
    logic [TIME_W-1:0]    sim_time;
    logic                 switch_is_open;
    logic [OUT_CNT_W-1:0] product_count;
    logic [OUT_CNT_W-1:0] burst_size;
    logic [TIME_W-1:0]    interarrival;
    logic                 interarrival_valid;
    logic                 sample_due;
    logic                 past_equil;
    logic                 run_done;
    logic                 stalled;
    int                   fail_count;
    int                   pending;
    int                   cycles;
    logic                 stall_mode;

    // Generous ceiling: 1316 requests, each a full block step plus long gaps both sides.
    localparam int CYCLE_LIMIT = 1_500_000;

    telegraph_burst_gillespie_step dut (.*);
    tbg_step_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Cycle counter doubles as the watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // The receiver stalls at random; stall_mode turns stalling off for stretches.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        if (stall_mode && $urandom_range(0, 9) == 0)
            out_stall <= ($urandom_range(0, 29) != 0) ? ~out_stall : 1'b1;
        else if (stall_mode)
            out_stall <= out_stall;
        else
            out_stall <= 1'b0;
    end

    // One write, then the enable drops before returning so back-to-back writes never collide.
    task automatic write_reg(cfg_reg_t idx, logic [47:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drops the request line, waits until every expected result has come
    // back, then lets the block settle so a write never lands during a step.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Sends one request, after a random gap unless told otherwise. The
    // request line stays up after acceptance; the next call or drain()
    // either replaces the request or drops the line.
    task automatic send_request(logic [31:0] r1, logic [31:0] r2, bit idle_first);
        int n;
        n = idle_first ? gap_len() : 0;
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        rand_time <= r1;
        rand_pick <= r2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random rates: mostly modest values, sometimes zero, full scale or a random word.
    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1 << 12, 1 << 20);
        endcase
    endfunction

    function automatic logic [47:0] pick_time();
        case ($urandom_range(0, 7))
            0: return 48'd0;
            1: return 48'hFFFF_FFFF_FFFF;
            2: return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
            default: return 48'($urandom_range(1, 1 << 22));
        endcase
    endfunction

    initial
    begin
        logic [31:0] r1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        rand_time = 32'd1;
        rand_pick = '0;
        out_stall = 1'b0;
        stall_mode = 1'b1;
        cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset values: extremes of both words, the zero
        // time word, and a close that reports a burst.
        send_request(32'd0, 32'd0, 0);
        send_request(32'd1, 32'hFFFF_FFFF, 0);
        send_request(32'hFFFF_FFFF, 32'h8000_0000, 0);
        send_request(32'h8000_0000, 32'h0000_0001, 1);
        send_request(32'h5555_5555, 32'hAAAA_AAAA, 1);
        send_request(32'hAAAA_AAAA, 32'h5555_5555, 1);
        for (int i = 0; i < 6; i++)
            send_request($urandom, $urandom, 1);
        drain();

        // All rates zero: the no-reaction case, which saturates time and pushes
        // the run to its end.
        write_reg(REG_RATE_OPEN, 48'd0);
        write_reg(REG_RATE_CLOSE, 48'd0);
        write_reg(REG_RATE_PRODUCE, 48'd0);
        write_reg(REG_RATE_DECAY, 48'd0);
        write_reg(REG_EQUIL_TIME, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_SAMPLE_INTERVAL, 48'd0);
        write_reg(REG_TOTAL_TIME, 48'hFFFF_FFFF_FFFF);
        send_request(32'h1234_5678, 32'h9ABC_DEF0, 0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        drain();

        // Full-scale rates: large propensities and tiny time steps.
        write_reg(REG_RATE_OPEN, 48'hFFFF_FFFF);
        write_reg(REG_RATE_CLOSE, 48'hFFFF_FFFF);
        write_reg(REG_RATE_PRODUCE, 48'hFFFF_FFFF);
        write_reg(REG_RATE_DECAY, 48'hFFFF_FFFF);
        for (int i = 0; i < 6; i++)
            send_request($urandom, $urandom, 1);
        // Hold the sender until every result is in.
        drain();

        // Random phases, each with fresh settings.
        for (int phase = 0; phase < 18; phase++)
        begin
            write_reg(REG_RATE_OPEN, 48'(pick_rate()));
            write_reg(REG_RATE_CLOSE, 48'(pick_rate()));
            write_reg(REG_RATE_PRODUCE, 48'(pick_rate()));
            write_reg(REG_RATE_DECAY, 48'(pick_rate()));
            write_reg(REG_EQUIL_TIME, pick_time());
            write_reg(REG_SAMPLE_INTERVAL, pick_time());
            write_reg(REG_TOTAL_TIME, pick_time());
            for (int i = 0; i < 72; i++)
            begin
                r1 = $urandom;
                send_request(r1, $urandom, $urandom_range(0, 3) != 0);
            end
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tbg_pkg.sv
rtl/tbg_ctrl.sv
rtl/tbg_datapath.sv
rtl/telegraph_burst_gillespie_step.sv
rtl/tbg_checker.sv
bench/tbg_step_checker.sv
bench/telegraph_burst_gillespie_step_test.sv
